// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle implication violated");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle implication violated");

`endif

// ===== sv/fqs_pkg.sv =====
`default_nettype none
package fqs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int POS_W       = 5;
  localparam int REQ_W       = 3;
  localparam int STATUS_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ    = 3'd0,
    REQ_DEQ    = 3'd1,
    REQ_PEEK   = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_LEN    = 3'd4
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== sv/fqs_cell.sv =====
`default_nettype none
module fqs_cell (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire fqs_pkg::cell_ctl_t                ctl,
  input  wire logic signed [fqs_pkg::DATA_W-1:0] key,
  input  wire logic                              prev_valid,
  input  wire logic signed [fqs_pkg::DATA_W-1:0] next_value,
  input  wire logic                              next_valid,
  output logic signed [fqs_pkg::DATA_W-1:0]      value,
  output logic                                   valid,
  output logic                                   match
);

  logic signed [fqs_pkg::DATA_W-1:0] value_r, value_nxt;
  logic                              valid_r, valid_nxt;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.deq) begin
      value_nxt = next_value;
      valid_nxt = next_valid;
    end else if (ctl.enq && prev_valid && !valid_r) begin
      value_nxt = key;
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;
  assign match = valid_r && (value_r == key);

endmodule
`default_nettype wire

// ===== sv/fifo_queue_with_search.sv =====
// A result strobes in the cycle after its item is accepted.
// Throughput: one item per cycle; busy stays low, and an enqueue or dequeue updates the cells from the accept cycle.
// Search compares all cells in parallel; the first match is encoded from a registered vector.
// Reset clears the cell valid bits, the count and the result strobe; stored values are kept.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module fifo_queue_with_search (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [fqs_pkg::REQ_W-1:0]          in_req_type,
  input  wire logic signed [fqs_pkg::DATA_W-1:0]  in_item_value,
  output logic                                    out_strobe,
  output logic [fqs_pkg::STATUS_W-1:0]            out_status,
  output logic signed [fqs_pkg::DATA_W-1:0]       out_front_value,
  output logic [fqs_pkg::POS_W-1:0]               out_match_position,
  output logic [fqs_pkg::POS_W-1:0]               out_entry_count
);

  localparam int D = fqs_pkg::QUEUE_DEPTH;

  logic signed [fqs_pkg::DATA_W-1:0] cell_value [D];
  logic [D-1:0]                      cell_valid;
  logic [D-1:0]                      cell_match;
  fqs_pkg::cell_ctl_t                ctl;

  logic [fqs_pkg::CNT_W-1:0]         count_r, count_nxt;
  logic                              strobe_r;
  fqs_pkg::status_t                  status_r, status_nxt;
  logic signed [fqs_pkg::DATA_W-1:0] front_r, front_nxt;
  logic [D-1:0]                      match_vec_r;
  logic                              search_r;
  logic [fqs_pkg::POS_W-1:0]         pos;

  logic accept, empty, full;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign empty  = (count_r == '0);
  assign full   = (count_r == fqs_pkg::CNT_W'(D));

  always_comb begin
    ctl.enq    = 1'b0;
    ctl.deq    = 1'b0;
    count_nxt  = count_r;
    status_nxt = fqs_pkg::ST_OK;
    front_nxt  = '0;
    case (in_req_type)
      fqs_pkg::REQ_ENQ: begin
        if (full) begin
          status_nxt = fqs_pkg::ST_FULL;
        end else begin
          ctl.enq   = accept;
          count_nxt = count_r + 1'b1;
        end
      end
      fqs_pkg::REQ_DEQ: begin
        if (empty) begin
          status_nxt = fqs_pkg::ST_EMPTY;
        end else begin
          ctl.deq   = accept;
          count_nxt = count_r - 1'b1;
          front_nxt = cell_value[0];
        end
      end
      fqs_pkg::REQ_PEEK: begin
        if (empty) begin
          status_nxt = fqs_pkg::ST_EMPTY;
        end else begin
          front_nxt = cell_value[0];
        end
      end
      fqs_pkg::REQ_SEARCH, fqs_pkg::REQ_LEN: begin
        if (empty) begin
          status_nxt = fqs_pkg::ST_EMPTY;
        end
      end
      default: begin
        status_nxt = fqs_pkg::ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic                              prev_v;
    logic signed [fqs_pkg::DATA_W-1:0] nv;
    logic                              nvld;
    if (i == 0) begin : g_head
      assign prev_v = 1'b1;
    end else begin : g_body
      assign prev_v = cell_valid[i-1];
    end
    if (i == D - 1) begin : g_tail
      assign nv   = '0;
      assign nvld = 1'b0;
    end else begin : g_link
      assign nv   = cell_value[i+1];
      assign nvld = cell_valid[i+1];
    end
    fqs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .key        (in_item_value),
      .prev_valid (prev_v),
      .next_value (nv),
      .next_valid (nvld),
      .value      (cell_value[i]),
      .valid      (cell_valid[i]),
      .match      (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      front_r     <= front_nxt;
      search_r    <= (in_req_type == fqs_pkg::REQ_SEARCH);
      match_vec_r <= (in_req_type == fqs_pkg::REQ_SEARCH) ? cell_match : '0;
    end
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_comb begin
    pos = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (match_vec_r[i]) begin
        pos = fqs_pkg::POS_W'(i + 1);
      end
    end
  end

  assign out_strobe         = strobe_r;
  assign out_status         = (search_r && status_r == fqs_pkg::ST_OK && match_vec_r == '0)
                              ? fqs_pkg::ST_NOTFOUND : status_r;
  assign out_front_value    = front_r;
  assign out_match_position = pos;
  assign out_entry_count    = fqs_pkg::POS_W'(count_r);

endmodule
`default_nettype wire

// ===== sv/fqs_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module fqs_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               start,
  input wire logic                               busy,
  input wire logic                               out_strobe,
  input wire logic [fqs_pkg::STATUS_W-1:0]       out_status,
  input wire logic signed [fqs_pkg::DATA_W-1:0]  out_front_value,
  input wire logic [fqs_pkg::POS_W-1:0]          out_match_position,
  input wire logic [fqs_pkg::POS_W-1:0]          out_entry_count
);

  localparam logic [fqs_pkg::POS_W-1:0] FULL_CNT = fqs_pkg::POS_W'(fqs_pkg::QUEUE_DEPTH);

  logic accept;
  logic res_full, res_empty, res_notfound;
  logic res_zero;

  assign accept       = start && !busy;
  assign res_full     = out_strobe && out_status == fqs_pkg::ST_FULL;
  assign res_empty    = out_strobe && out_status == fqs_pkg::ST_EMPTY;
  assign res_notfound = out_strobe && out_status == fqs_pkg::ST_NOTFOUND;
  assign res_zero     = out_entry_count == '0 && out_match_position == '0 &&
                        out_front_value == '0;

  `ASSERT_NEXT(a_one_result, clk, rst_n, accept, out_strobe)
  `ASSERT_NEXT(a_no_stray, clk, rst_n, !accept, !out_strobe)
  `ASSERT_IMPLY(a_full_count, clk, rst_n, res_full, out_entry_count == FULL_CNT)
  `ASSERT_IMPLY(a_empty_res, clk, rst_n, res_empty, res_zero)
  `ASSERT_IMPLY(a_notfound, clk, rst_n, res_notfound, out_match_position == '0 && out_entry_count != '0)

endmodule

bind fifo_queue_with_search fqs_checker u_fqs_checker (.*);
`default_nettype wire
